FILE: src/scfp_pkg.sv
// scfp_pkg: shared types and codes of the sync/checksum frame parser
// no dependencies; used by the interfaces, scfp_core and the top level
package scfp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned EV_W   = 3;
  localparam int unsigned PH_W   = 2;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // reset value of the sync byte register
  localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hAA;

  // register index of the sync byte
  localparam logic [0:0] REG_SYNC_BYTE = 1'b0;

  // parser phases; the unused code behaves as waiting for the check byte
  localparam logic [PH_W-1:0] PH_WAIT_SYNC    = 2'd0;
  localparam logic [PH_W-1:0] PH_WAIT_PAYLOAD = 2'd1;
  localparam logic [PH_W-1:0] PH_WAIT_CHECK   = 2'd2;

  // event codes
  localparam logic [EV_W-1:0] EV_NONE       = 3'd0;
  localparam logic [EV_W-1:0] EV_SYNC       = 3'd1;
  localparam logic [EV_W-1:0] EV_VALID      = 3'd2;
  localparam logic [EV_W-1:0] EV_BAD        = 3'd3;
  localparam logic [EV_W-1:0] EV_BAD_RESYNC = 3'd4;
  localparam logic [EV_W-1:0] EV_CS_RESYNC  = 3'd5;

  // item modes
  localparam logic MODE_DATA = 1'b0;
  localparam logic MODE_CS   = 1'b1;

  // one input word
  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] rx_byte;
    logic              cs_level;
  } in_item_t;

  // one result word
  typedef struct packed {
    logic              frame_valid;
    logic [BYTE_W-1:0] payload;
    logic [EV_W-1:0]   event_code;
    logic [BYTE_W-1:0] expected_check;
    logic [CNT_W-1:0]  good_frames;
    logic [CNT_W-1:0]  bad_frames;
  } out_item_t;

endpackage

FILE: src/scfp_if.sv
// scfp_in_if / scfp_out_if: valid/ready channels of the frame parser
// depends on scfp_pkg for field widths
interface scfp_in_if;
  import scfp_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [BYTE_W-1:0] rx_byte;
  logic              cs_level;

  modport source (output valid, output mode, output rx_byte, output cs_level,
                  input ready);
  modport sink   (input valid, input mode, input rx_byte, input cs_level,
                  output ready);
endinterface

interface scfp_out_if;
  import scfp_pkg::*;

  logic              valid;
  logic              ready;
  logic              frame_valid;
  logic [BYTE_W-1:0] payload;
  logic [EV_W-1:0]   event_code;
  logic [BYTE_W-1:0] expected_check;
  logic [CNT_W-1:0]  good_frames;
  logic [CNT_W-1:0]  bad_frames;

  modport source (output valid, output frame_valid, output payload,
                  output event_code, output expected_check,
                  output good_frames, output bad_frames, input ready);
  modport sink   (input valid, input frame_valid, input payload,
                  input event_code, input expected_check,
                  input good_frames, input bad_frames, output ready);
endinterface

FILE: src/scfp_core.sv
// scfp_core: parser state and the per-word decision logic
// depends on scfp_pkg; state advances on every word processed (step)
module scfp_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  scfp_pkg::in_item_t         item,
  input  logic [scfp_pkg::BYTE_W-1:0] sync_byte,
  output scfp_pkg::out_item_t        res
);
  import scfp_pkg::*;

  logic [PH_W-1:0]   phase_r, phase_nxt;
  logic [BYTE_W-1:0] held_r, held_nxt;
  logic [CNT_W-1:0]  good_r, good_nxt;
  logic [CNT_W-1:0]  bad_r, bad_nxt;
  logic              prev_cs_r, prev_cs_nxt;
  logic [EV_W-1:0]   ev;
  logic              valid;
  logic [BYTE_W-1:0] expect_chk;

  assign expect_chk = sync_byte ^ held_r;

  // next-state decision for one word
  always_comb begin
    phase_nxt   = phase_r;
    held_nxt    = held_r;
    good_nxt    = good_r;
    bad_nxt     = bad_r;
    prev_cs_nxt = prev_cs_r;
    ev          = EV_NONE;
    valid       = 1'b0;
    if (item.mode == MODE_DATA) begin
      case (phase_r)
        PH_WAIT_SYNC: begin
          if (item.rx_byte == sync_byte) begin
            phase_nxt = PH_WAIT_PAYLOAD;
            ev        = EV_SYNC;
          end
        end
        PH_WAIT_PAYLOAD: begin
          held_nxt  = item.rx_byte;
          phase_nxt = PH_WAIT_CHECK;
        end
        default: begin
          // check byte, also for the unused phase code
          if (item.rx_byte == expect_chk) begin
            good_nxt  = good_r + 16'd1;
            valid     = 1'b1;
            phase_nxt = PH_WAIT_SYNC;
            ev        = EV_VALID;
          end else begin
            bad_nxt = bad_r + 16'd1;
            if (item.rx_byte == sync_byte) begin
              phase_nxt = PH_WAIT_PAYLOAD;
              ev        = EV_BAD_RESYNC;
            end else begin
              phase_nxt = PH_WAIT_SYNC;
              ev        = EV_BAD;
            end
          end
        end
      endcase
    end else begin
      // chip-select rising edge mid-frame
      if (!prev_cs_r && item.cs_level && phase_r != PH_WAIT_SYNC) begin
        phase_nxt = PH_WAIT_SYNC;
        held_nxt  = '0;
        ev        = EV_CS_RESYNC;
      end
      prev_cs_nxt = item.cs_level;
    end
  end

  // result as seen after this word
  always_comb begin
    res.frame_valid    = valid;
    res.payload        = held_nxt;
    res.event_code     = ev;
    res.expected_check = sync_byte ^ held_nxt;
    res.good_frames    = good_nxt;
    res.bad_frames     = bad_nxt;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WAIT_SYNC;
      held_r    <= '0;
      good_r    <= '0;
      bad_r     <= '0;
      prev_cs_r <= 1'b1;
    end else if (step) begin
      phase_r   <= phase_nxt;
      held_r    <= held_nxt;
      good_r    <= good_nxt;
      bad_r     <= bad_nxt;
      prev_cs_r <= prev_cs_nxt;
    end
  end

  // good count moves by one exactly on a valid frame
  a_good_inc: assert property (@(posedge clk) disable iff (!rst_n)
    step && ev == EV_VALID |=> good_r == $past(good_r) + 16'd1)
    else $error("good frame count did not advance");

  // bad count only moves on a failed check
  a_bad_hold: assert property (@(posedge clk) disable iff (!rst_n)
    step && ev != EV_BAD && ev != EV_BAD_RESYNC |=> $stable(bad_r))
    else $error("bad frame count moved without a failed check");

  // chip-select resync leaves the parser waiting for sync with no payload
  a_cs_resync: assert property (@(posedge clk) disable iff (!rst_n)
    step && ev == EV_CS_RESYNC |=> phase_r == PH_WAIT_SYNC && held_r == '0)
    else $error("cs resync did not clear the parser");

  // resync after a bad check goes straight to the payload phase
  a_bad_resync: assert property (@(posedge clk) disable iff (!rst_n)
    step && ev == EV_BAD_RESYNC |=> phase_r == PH_WAIT_PAYLOAD)
    else $error("bad check resync did not enter payload phase");

endmodule

FILE: src/sync_checksum_frame_parser_top.sv
// sync_checksum_frame_parser_top: sync/payload/check frame parser on scfp_pkg, scfp_if, scfp_core
// an accepted word passes the input register, then the result register, before its result is offered
// throughput: one word per cycle; the decision is one compare and XOR per word
// input stalls only while both registers hold words and the result is not taken
// reset (rst_n, sync): waits for sync, counters and payload zero, last cs high, sync byte 0xAA
// result valid rises at the edge where the word leaves the input register, fields held until taken
module sync_checksum_frame_parser_top (
  input  logic                       clk,
  input  logic                       rst_n,
  scfp_in_if.sink                    in_ch,
  scfp_out_if.source                 out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [scfp_pkg::ADDR_W-1:0] paddr,
  input  logic [scfp_pkg::DATA_W-1:0] pwdata,
  output logic [scfp_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import scfp_pkg::*;

  logic [BYTE_W-1:0] sync_r;
  logic              s1_valid_r, s1_valid_nxt;
  in_item_t          s1_item_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_res_r;
  out_item_t         core_res;
  logic              out_adv;
  logic              step;
  logic              in_acc;
  logic              reg_sel;

  // config port: one register, decoded on the word address
  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1] == REG_SYNC_BYTE;
  assign prdata  = reg_sel ? {{(DATA_W-BYTE_W){1'b0}}, sync_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= SYNC_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      sync_r <= pwdata[BYTE_W-1:0];
    end
  end

  // handshake between input register and result register
  assign out_adv      = !out_valid_r || out_ch.ready;
  assign step         = s1_valid_r && out_adv;
  assign in_ch.ready  = !s1_valid_r || out_adv;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_acc ? 1'b1 : (step ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = step ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.mode     <= in_ch.mode;
      s1_item_r.rx_byte  <= in_ch.rx_byte;
      s1_item_r.cs_level <= in_ch.cs_level;
    end
  end

  scfp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (s1_item_r),
    .sync_byte (sync_r),
    .res       (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.frame_valid    = out_res_r.frame_valid;
  assign out_ch.payload        = out_res_r.payload;
  assign out_ch.event_code     = out_res_r.event_code;
  assign out_ch.expected_check = out_res_r.expected_check;
  assign out_ch.good_frames    = out_res_r.good_frames;
  assign out_ch.bad_frames     = out_res_r.bad_frames;

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking testbench of sync_checksum_frame_parser_top
// predicts every result word from its own parser state and compares field by field
// depends on scfp_pkg, scfp_if and the parser RTL
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import scfp_pkg::*;

  localparam logic [ADDR_W-1:0] SYNC_ADDR  = ADDR_W'(4 * int'(REG_SYNC_BYTE));
  // first address past the register map, writes there must be dropped
  localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(4 * (int'(REG_SYNC_BYTE) + 1));
  localparam int unsigned MAX_WAIT   = 16;
  localparam int unsigned LONG_HOLD  = 300;
  localparam int unsigned RAND_WORDS = 180;

  logic clk = 1'b0;
  logic rst_n;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  scfp_in_if  in_ch ();
  scfp_out_if out_ch ();

  sync_checksum_frame_parser_top u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // words waiting to be sent and results waiting to arrive
  in_item_t  pending_words[$];
  out_item_t expected_results[$];
  int unsigned mismatches = 0;

  // idling controls, set by the stimulus at the falling edge; the hold counter counts down at the rising edge
  logic send_idle = 1'b0;
  logic recv_idle = 1'b0;
  int unsigned hold_len = 0;
  logic hold_on = 1'b0;

  // parser state as predicted
  logic [BYTE_W-1:0] pred_sync  = SYNC_RESET;
  logic [PH_W-1:0]   pred_phase = PH_WAIT_SYNC;
  logic [BYTE_W-1:0] pred_held  = '0;
  logic [CNT_W-1:0]  pred_good  = '0;
  logic [CNT_W-1:0]  pred_bad   = '0;
  logic              pred_cs    = 1'b1;

  in_item_t    sent_word;
  in_item_t    next_word;
  out_item_t   got_word;
  out_item_t   want_word;
  int unsigned send_wait;
  int unsigned recv_wait;

  // advance the predicted parser by one word and return the result word
  function automatic out_item_t parse_word(in_item_t w);
    out_item_t r;
    r = '0;
    r.event_code = EV_NONE;
    if (w.mode == MODE_DATA) begin
      if (pred_phase == PH_WAIT_SYNC) begin
        if (w.rx_byte == pred_sync) begin
          pred_phase   = PH_WAIT_PAYLOAD;
          r.event_code = EV_SYNC;
        end
      end else if (pred_phase == PH_WAIT_PAYLOAD) begin
        pred_held  = w.rx_byte;
        pred_phase = PH_WAIT_CHECK;
      end else if (w.rx_byte == (pred_sync ^ pred_held)) begin
        // a correct check wins even when it also equals the sync byte
        pred_good     = pred_good + 1'b1;
        r.frame_valid = 1'b1;
        pred_phase    = PH_WAIT_SYNC;
        r.event_code  = EV_VALID;
      end else begin
        pred_bad = pred_bad + 1'b1;
        if (w.rx_byte == pred_sync) begin
          pred_phase   = PH_WAIT_PAYLOAD;
          r.event_code = EV_BAD_RESYNC;
        end else begin
          pred_phase   = PH_WAIT_SYNC;
          r.event_code = EV_BAD;
        end
      end
    end else begin
      // rising chip-select inside a frame drops the frame
      if (!pred_cs && w.cs_level && pred_phase != PH_WAIT_SYNC) begin
        pred_phase   = PH_WAIT_SYNC;
        pred_held    = '0;
        r.event_code = EV_CS_RESYNC;
      end
      pred_cs = w.cs_level;
    end
    r.payload        = pred_held;
    r.expected_check = pred_sync ^ pred_held;
    r.good_frames    = pred_good;
    r.bad_frames     = pred_bad;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // data words carry a random chip-select bit and vice versa
  function automatic void push_byte(logic [BYTE_W-1:0] b);
    in_item_t w;
    w.mode     = MODE_DATA;
    w.rx_byte  = b;
    w.cs_level = 1'($urandom);
    pending_words.push_back(w);
  endfunction

  function automatic void push_cs(logic level);
    in_item_t w;
    w.mode     = MODE_CS;
    w.rx_byte  = BYTE_W'($urandom);
    w.cs_level = level;
    pending_words.push_back(w);
  endfunction

  // well-formed frames as the largest share, the rest broken frames, glitches and noise
  task automatic add_random(int unsigned n);
    int unsigned added;
    int unsigned pick;
    logic [BYTE_W-1:0] pl;
    added = 0;
    while (added < n) begin
      pick = $urandom_range(0, 99);
      pl   = BYTE_W'($urandom);
      if (pick < 45) begin
        push_byte(pred_sync);
        push_byte(pl);
        push_byte(pred_sync ^ pl);
        added += 3;
      end else if (pick < 55) begin
        push_byte(pred_sync);
        push_byte(pl);
        push_byte(BYTE_W'($urandom));
        added += 3;
      end else if (pick < 62) begin
        push_byte(pred_sync);
        push_byte(pl);
        push_byte(pred_sync);
        added += 3;
      end else if (pick < 72) begin
        push_byte(pred_sync);
        if ($urandom_range(0, 1)) push_byte(pl);
        push_cs(1'b0);
        push_cs(1'b1);
        added += 4;
      end else if (pick < 85) begin
        push_byte(pl);
        added += 1;
      end else begin
        push_cs(1'($urandom));
        added += 1;
      end
    end
  endtask

  // wait until every word is sent and every result has arrived
  task automatic drain();
    while (pending_words.size() != 0 || expected_results.size() != 0 || in_ch.valid)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_read(input logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write, then read the sync byte back
  task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] rd;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == SYNC_ADDR) pred_sync = data[BYTE_W-1:0];
    cfg_read(SYNC_ADDR, rd);
    check_field("sync_byte", 32'(pred_sync), 32'(rd[BYTE_W-1:0]));
  endtask

  // input driver: per-word gap, holds the word until it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        sent_word.mode     = in_ch.mode;
        sent_word.rx_byte  = in_ch.rx_byte;
        sent_word.cs_level = in_ch.cs_level;
        expected_results.push_back(parse_word(sent_word));
        send_wait = send_idle ? $urandom_range(0, MAX_WAIT) : 0;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // word still on offer
      end else if (send_wait > 0) begin
        send_wait--;
        in_ch.valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        next_word = pending_words.pop_front();
        in_ch.valid    <= 1'b1;
        in_ch.mode     <= next_word.mode;
        in_ch.rx_byte  <= next_word.rx_byte;
        in_ch.cs_level <= next_word.cs_level;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_len > 0) begin
      hold_on <= 1'b1;
      hold_len = hold_len - 1;
    end else begin
      hold_on <= 1'b0;
    end
  end

  // result monitor: checks each taken word against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_word.frame_valid    = out_ch.frame_valid;
        got_word.payload        = out_ch.payload;
        got_word.event_code     = out_ch.event_code;
        got_word.expected_check = out_ch.expected_check;
        got_word.good_frames    = out_ch.good_frames;
        got_word.bad_frames     = out_ch.bad_frames;
        if (expected_results.size() == 0) begin
          $error("result word with no prediction waiting");
          mismatches++;
        end else begin
          want_word = expected_results.pop_front();
          check_field("frame_valid", 32'(want_word.frame_valid), 32'(got_word.frame_valid));
          check_field("payload", 32'(want_word.payload), 32'(got_word.payload));
          check_field("event_code", 32'(want_word.event_code), 32'(got_word.event_code));
          check_field("expected_check", 32'(want_word.expected_check),
                      32'(got_word.expected_check));
          check_field("good_frames", 32'(want_word.good_frames), 32'(got_word.good_frames));
          check_field("bad_frames", 32'(want_word.bad_frames), 32'(got_word.bad_frames));
        end
        recv_wait = recv_idle ? $urandom_range(0, MAX_WAIT) : 0;
      end
      if (hold_on) begin
        out_ch.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // run limit
  initial begin
    #(20_000_000);
    $display("[sync_checksum_frame_parser_top] ERROR");
    $finish;
  end

  // reset, register settings and stimulus phases
  initial begin
    logic [DATA_W-1:0] rd;
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_ch.valid    = 1'b0;
    in_ch.mode     = MODE_DATA;
    in_ch.rx_byte  = '0;
    in_ch.cs_level = 1'b1;
    out_ch.ready   = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // sync byte after reset
    cfg_read(SYNC_ADDR, rd);
    check_field("sync_byte", 32'(SYNC_RESET), 32'(rd[BYTE_W-1:0]));
    @(negedge clk);

    // directed words with the reset sync byte
    send_idle = 1'b1;
    recv_idle = 1'b1;
    push_byte(8'h00);                   // noise while waiting for sync
    push_byte(8'hFF);
    push_cs(1'b0);                      // chip-select edges outside a frame
    push_cs(1'b1);
    push_byte(pred_sync);               // zero payload, check equals sync
    push_byte(8'h00);
    push_byte(pred_sync);
    push_byte(pred_sync);               // all-ones payload
    push_byte(8'hFF);
    push_byte(pred_sync ^ 8'hFF);
    push_byte(pred_sync);               // bad check
    push_byte(8'h12);
    push_byte(8'h00);
    push_byte(pred_sync);               // bad check that is a sync byte
    push_byte(8'h34);
    push_byte(pred_sync);
    push_byte(8'h56);
    push_byte(pred_sync ^ 8'h56);
    push_byte(pred_sync);               // chip-select rise while waiting for payload
    push_cs(1'b0);
    push_cs(1'b1);
    push_byte(pred_sync);               // level high without an edge, then a rise
    push_byte(8'h77);
    push_cs(1'b1);
    push_cs(1'b0);
    push_cs(1'b1);
    push_byte(pred_sync);               // payload equal to the sync byte
    push_byte(pred_sync);
    push_byte(8'h00);
    add_random(RAND_WORDS);
    drain();

    // sync byte zero, no idling
    send_idle = 1'b0;
    recv_idle = 1'b0;
    cfg_write(SYNC_ADDR, 32'h0000_0000);
    @(negedge clk);
    add_random(RAND_WORDS);
    drain();

    // sync byte all ones, receiver held off while words keep coming
    cfg_write(SYNC_ADDR, 32'h0000_00FF);
    @(negedge clk);
    hold_len = LONG_HOLD;
    add_random(RAND_WORDS);
    drain();

    // write past the register map is dropped, then a random sync byte
    send_idle = 1'b1;
    cfg_write(SPARE_ADDR, $urandom);
    cfg_write(SYNC_ADDR, 32'($urandom_range(0, 255)));
    @(negedge clk);
    add_random(RAND_WORDS);
    drain();

    // random sync byte, only the receiver idles
    send_idle = 1'b0;
    recv_idle = 1'b1;
    cfg_write(SYNC_ADDR, 32'($urandom_range(0, 255)));
    @(negedge clk);
    add_random(RAND_WORDS);
    drain();

    // last random sync byte, both sides idle
    send_idle = 1'b1;
    recv_idle = 1'b1;
    cfg_write(SYNC_ADDR, 32'($urandom_range(0, 255)));
    @(negedge clk);
    add_random(RAND_WORDS);
    drain();

    if (mismatches == 0) begin
      $display("[sync_checksum_frame_parser_top] OK");
    end else begin
      $display("[sync_checksum_frame_parser_top] ERROR");
    end
    $finish;
  end

endmodule
